@@ design/rhcc_pkg.sv @@
// Shared types and constants for the RGB565 to HSV color classifier.
// Used by the divider stage and by the top level; depends on nothing else.
package rhcc_pkg;

	// Widened channel width and number of quotient bits resolved per divider stage.
	localparam int unsigned CH_W      = 8;
	localparam int unsigned DIV_STEPS = 2;

	// Hue arithmetic constants.
	localparam logic [7:0] HUE_SECTOR = 8'd43;
	localparam logic [7:0] HUE_BASE_R = 8'd0;
	localparam logic [7:0] HUE_BASE_G = 8'd85;
	localparam logic [7:0] HUE_BASE_B = 8'd171;

	// Classification windows.
	localparam logic [7:0] RED_H_LO_MAX   = 8'd30;
	localparam logic [7:0] RED_H_HI_MIN   = 8'd210;
	localparam logic [7:0] GREEN_H_MIN    = 8'd55;
	localparam logic [7:0] GREEN_H_MAX    = 8'd120;
	localparam logic [7:0] GREEN_S_MIN    = 8'd25;
	localparam logic [7:0] GREEN_V_MIN    = 8'd25;
	localparam logic [7:0] BLUE_H_MIN     = 8'd120;
	localparam logic [7:0] BLUE_H_MAX     = 8'd165;
	localparam logic [7:0] BLUE_S_MIN     = 8'd35;
	localparam logic [7:0] YELLOW_H_MIN   = 8'd25;
	localparam logic [7:0] YELLOW_H_MAX   = 8'd55;
	localparam logic [7:0] YELLOW_S_MIN   = 8'd50;
	localparam logic [7:0] BRIGHT_V_MIN   = 8'd30;
	localparam logic [7:0] BRIGHT_V_MAX   = 8'd250;
	localparam logic [7:0] ORANGE_H_HI    = 8'd230;
	localparam logic [7:0] ORANGE_H_LO    = 8'd15;
	localparam logic [7:0] ORANGE_H_LIMIT = 8'd180;

	// Which channel holds the maximum; selects the hue base.
	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	// Output color classes.
	typedef enum logic [2:0] {
		CLS_NONE   = 3'd0,
		CLS_RED    = 3'd1,
		CLS_GREEN  = 3'd2,
		CLS_BLUE   = 3'd3,
		CLS_YELLOW = 3'd4,
		CLS_ORANGE = 3'd5
	} class_t;

	// One restoring-division lane: partial remainder, unused numerator bits, quotient.
	typedef struct packed {
		logic [CH_W-1:0] rem;
		logic [CH_W-1:0] num;
		logic [CH_W-1:0] quo;
	} div_lane_t;

	// Payload carried through the divider stages.
	typedef struct packed {
		logic [CH_W-1:0] v;
		logic [CH_W-1:0] span;
		sector_t         sector;
		logic            neg;
		div_lane_t       sat;
		div_lane_t       hue;
	} stage_t;

endpackage

@@ design/rhcc_div_stage.sv @@
// One stage of the two-lane restoring divider (saturation and hue offset).
// Depends on rhcc_pkg for the stage payload type and the step count.
module rhcc_div_stage (
	input  rhcc_pkg::stage_t st_in,
	output rhcc_pkg::stage_t st_out
);
	import rhcc_pkg::*;

	// Resolve DIV_STEPS quotient bits of one lane against its divisor.
	function automatic div_lane_t lane_step(input div_lane_t ln, input logic [CH_W-1:0] dvs);
		div_lane_t     r;
		logic [CH_W:0] trial;
		r = ln;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial = {r.rem, r.num[CH_W-1]};
			r.num = {r.num[CH_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs}) begin
				trial = trial - {1'b0, dvs};
				r.quo = {r.quo[CH_W-2:0], 1'b1};
			end else begin
				r.quo = {r.quo[CH_W-2:0], 1'b0};
			end
			r.rem = trial[CH_W-1:0];
		end
		return r;
	endfunction

	// Saturation divides by V, hue offset divides by the channel span.
	always_comb begin
		st_out     = st_in;
		st_out.sat = lane_step(st_in.sat, st_in.v);
		st_out.hue = lane_step(st_in.hue, st_in.span);
	end

endmodule

@@ design/rgb565_hsv_color_classifier.sv @@
// Top level of the RGB565 to HSV color classifier: a seven-stage pipeline.
// Depends on rhcc_pkg and instantiates rhcc_div_stage four times.
//
//   channel | ports                                          | direction
//   pixel   | pixel_valid, pixel_stall, pixel                | in
//   result  | result_valid, result_stall, hue, saturation,   | out
//           | brightness, color_class                        |
//
// One pixel enters per cycle while pixel_stall is low; each result is registered in stages 1 to 7.
// The depth is set by the two 8-bit divisions, resolved two quotient bits per
// stage over four stages. Reset clears all valid bits; data registers are not reset.
// Each full stage holds while the stage after it is full and held, so a stall at the
// output fills bubbles first and only then stalls the input.
module rgb565_hsv_color_classifier (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pixel_valid,
	output logic                       pixel_stall,
	input  logic [15:0]                pixel,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [rhcc_pkg::CH_W-1:0]  hue,
	output logic [rhcc_pkg::CH_W-1:0]  saturation,
	output logic [rhcc_pkg::CH_W-1:0]  brightness,
	output logic [2:0]                 color_class
);
	import rhcc_pkg::*;

	// Valid bits and stage enables.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	// Stage 1 registers.
	logic [CH_W-1:0] mx_s1, mn_s1, opa_s1, opb_s1;
	sector_t         sector_s1;

	// Divider stage payloads.
	stage_t st_s2, st_s3, st_s4, st_s5, st_s6;
	stage_t dv3, dv4, dv5, dv6;

	// Output registers.
	logic [CH_W-1:0] hue_s7, sat_s7, val_s7;
	class_t          cls_s7;

	// Stage 1 combinational signals.
	logic [CH_W-1:0] r_c, g_c, b_c, mx_c, mn_c, opa_c, opb_c;
	sector_t         sector_c;

	// Stage 2 combinational signals.
	logic [CH_W-1:0] span_c, mag_c;
	logic            neg_c;
	logic [13:0]     numh_c;
	logic [15:0]     nums_c;
	stage_t          st2_c;

	// Output stage combinational signals.
	logic [CH_W-1:0] base_c, offs_c, h_c, s_c;
	class_t          cls_c;

	// A stage loads when it is empty or its successor is loading.
	assign en7 = !vld_s7 || !result_stall;
	assign en6 = !vld_s6 || en7;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign pixel_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= pixel_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
			if (en7) vld_s7 <= vld_s6;
		end
	end

	// Stage 1: widen channels, find max and min, pick the hue sector and operands.
	always_comb begin
		r_c  = {pixel[15:11], pixel[15:13]};
		g_c  = {pixel[10:5], pixel[10:9]};
		b_c  = {pixel[4:0], pixel[4:2]};
		mx_c = r_c;
		if (g_c > mx_c) mx_c = g_c;
		if (b_c > mx_c) mx_c = b_c;
		mn_c = r_c;
		if (g_c < mn_c) mn_c = g_c;
		if (b_c < mn_c) mn_c = b_c;
		if (mx_c == r_c) begin
			sector_c = SECT_RED;
			opa_c    = g_c;
			opb_c    = b_c;
		end else if (mx_c == g_c) begin
			sector_c = SECT_GREEN;
			opa_c    = b_c;
			opb_c    = r_c;
		end else begin
			sector_c = SECT_BLUE;
			opa_c    = r_c;
			opb_c    = g_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			mx_s1     <= mx_c;
			mn_s1     <= mn_c;
			opa_s1    <= opa_c;
			opb_s1    <= opb_c;
			sector_s1 <= sector_c;
		end
	end

	// Stage 2: span, signed difference magnitude, and the two dividends.
	always_comb begin
		span_c = mx_s1 - mn_s1;
		neg_c  = opa_s1 < opb_s1;
		mag_c  = neg_c ? (opb_s1 - opa_s1) : (opa_s1 - opb_s1);
		numh_c = {6'd0, mag_c} * {6'd0, HUE_SECTOR};
		nums_c = {span_c, 8'h00} - {8'h00, span_c};
		st2_c.v        = mx_s1;
		st2_c.span     = span_c;
		st2_c.sector   = sector_s1;
		st2_c.neg      = neg_c;
		st2_c.sat.rem  = nums_c[15:8];
		st2_c.sat.num  = nums_c[7:0];
		st2_c.sat.quo  = '0;
		st2_c.hue.rem  = {2'b00, numh_c[13:8]};
		st2_c.hue.num  = numh_c[7:0];
		st2_c.hue.quo  = '0;
	end

	always_ff @(posedge clk) begin
		if (en2) st_s2 <= st2_c;
	end

	// Stages 3 to 6: two quotient bits per stage in each lane.
	rhcc_div_stage u_div3 (.st_in(st_s2), .st_out(dv3));
	rhcc_div_stage u_div4 (.st_in(st_s3), .st_out(dv4));
	rhcc_div_stage u_div5 (.st_in(st_s4), .st_out(dv5));
	rhcc_div_stage u_div6 (.st_in(st_s5), .st_out(dv6));

	always_ff @(posedge clk) begin
		if (en3) st_s3 <= dv3;
		if (en4) st_s4 <= dv4;
		if (en5) st_s5 <= dv5;
		if (en6) st_s6 <= dv6;
	end

	// Stage 7: hue from base and signed quotient, black and gray cases, classify.
	always_comb begin
		case (st_s6.sector)
			SECT_RED:   base_c = HUE_BASE_R;
			SECT_GREEN: base_c = HUE_BASE_G;
			SECT_BLUE:  base_c = HUE_BASE_B;
			default:    base_c = HUE_BASE_R;
		endcase
		offs_c = st_s6.neg ? (8'd0 - st_s6.hue.quo) : st_s6.hue.quo;
		h_c    = base_c + offs_c;
		s_c    = st_s6.sat.quo;
		if (st_s6.v == '0) begin
			h_c = '0;
			s_c = '0;
		end else if (s_c == '0 || st_s6.span == '0) begin
			h_c = '0;
		end

		if (h_c <= RED_H_LO_MAX || h_c >= RED_H_HI_MIN) begin
			cls_c = CLS_RED;
		end else if (h_c >= GREEN_H_MIN && h_c <= GREEN_H_MAX &&
				s_c >= GREEN_S_MIN && st_s6.v >= GREEN_V_MIN) begin
			cls_c = CLS_GREEN;
		end else if (h_c >= BLUE_H_MIN && h_c <= BLUE_H_MAX && s_c >= BLUE_S_MIN &&
				st_s6.v >= BRIGHT_V_MIN && st_s6.v <= BRIGHT_V_MAX) begin
			cls_c = CLS_BLUE;
		end else if (h_c >= YELLOW_H_MIN && h_c <= YELLOW_H_MAX && s_c >= YELLOW_S_MIN &&
				st_s6.v >= BRIGHT_V_MIN && st_s6.v <= BRIGHT_V_MAX) begin
			cls_c = CLS_YELLOW;
		end else if ((h_c >= ORANGE_H_HI || h_c <= ORANGE_H_LO) && h_c <= ORANGE_H_LIMIT) begin
			cls_c = CLS_ORANGE;
		end else begin
			cls_c = CLS_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			hue_s7 <= h_c;
			sat_s7 <= s_c;
			val_s7 <= st_s6.v;
			cls_s7 <= cls_c;
		end
	end

	// Result transaction ports.
	assign result_valid = vld_s7;
	assign hue          = hue_s7;
	assign saturation   = sat_s7;
	assign brightness   = val_s7;
	assign color_class  = cls_s7;

endmodule
